/* design/lalg_pkg.sv */
// ----------------------------------------------------------------------------
// lalg_pkg: shared types and constants of the look-ahead limiter gain stage
// Field widths, Q formats, register indexes and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package lalg_pkg;

	// field widths
	localparam int CH_W     = 3;   // channel field
	localparam int SAMPLE_W = 24;  // Q1.23 sample
	localparam int LEVEL_W  = 24;  // Q1.23 magnitudes: peak, threshold
	localparam int GAIN_W   = 17;  // Q1.16 gain
	localparam int COEF_W   = 17;  // Q1.16 weight, 65536 = 1.0
	localparam int FRAC_W   = 16;  // gain fraction bits

	// gain state
	localparam int CHANNELS = 8;   // power of two: index is the low channel bits
	localparam int IDX_W    = $clog2(CHANNELS);
	localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1 << FRAC_W);

	// serial divider: threshold*2^16/d with threshold < d gives FRAC_W bits
	localparam int QUO_W     = FRAC_W;
	localparam int DIV_CNT_W = $clog2(QUO_W);

	// shared multiplier: gain x magnitude
	localparam int PROD_W = GAIN_W + LEVEL_W;

	// stream words
	localparam int S_TDATA_W = 48;  // sample, peak_level
	localparam int M_TDATA_W = 48;  // out_sample, applied_gain, zero pad

	// configuration port
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_ATTACK    = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_RELEASE   = 2'd2;

	localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 24'd8388608;
	localparam logic [COEF_W-1:0]  ATTACK_RST    = 17'd0;
	localparam logic [COEF_W-1:0]  RELEASE_RST   = 17'd65000;

	// controller -> datapath
	typedef struct packed {
		logic load;         // capture input transaction, read channel gain
		logic div_start;    // launch a division
		logic div_sel;      // 0: threshold/peak, 1: threshold/|sample|
		logic take_target;  // latch target gain
		logic sel_weight;   // pick attack or release weight
		logic mul1;         // acc = w * gain
		logic mul2;         // acc += (1 - w) * target
		logic upd;          // smoothed gain out of acc, write channel state
		logic take_clamp;   // applied = min(gain, clamp)
		logic scale;        // acc = applied * |sample|
		logic out_load;     // load output register
	} lalg_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_busy;
	} lalg_sts_t;

endpackage

/* design/lalg_div.sv */
// ----------------------------------------------------------------------------
// lalg_div: restoring serial divider
// Computes floor(num * 2^16 / den), one quotient bit per cycle. Valid for
// num < den; otherwise the quotient is garbage and the caller ignores it.
// ----------------------------------------------------------------------------
module lalg_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lalg_pkg::LEVEL_W-1:0]  num,
	input  logic [lalg_pkg::LEVEL_W-1:0]  den,
	output logic                          busy,
	output logic [lalg_pkg::QUO_W-1:0]    quo
);

	logic                              busy_q;
	logic [lalg_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [lalg_pkg::LEVEL_W-1:0]      rem_q;
	logic [lalg_pkg::LEVEL_W-1:0]      den_q;
	logic [lalg_pkg::QUO_W-1:0]        quo_q;
	logic [lalg_pkg::LEVEL_W:0]        shifted;
	logic [lalg_pkg::LEVEL_W:0]        diff;
	logic                              fits;

	assign shifted = {rem_q, 1'b0};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = (shifted >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == lalg_pkg::DIV_CNT_W'(lalg_pkg::QUO_W - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[lalg_pkg::LEVEL_W-1:0] : shifted[lalg_pkg::LEVEL_W-1:0];
			quo_q <= {quo_q[lalg_pkg::QUO_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

/* design/lalg_datapath.sv */
// ----------------------------------------------------------------------------
// lalg_datapath: registers, divider, multiplier and gain state
// Works one item through target, smoothing, clamp and scaling steps under
// controller commands; holds configuration and the output payload.
// ----------------------------------------------------------------------------
module lalg_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lalg_pkg::lalg_cmd_t                cmd,
	output lalg_pkg::lalg_sts_t                sts,
	// configuration
	input  logic                               cfg_we,
	input  logic [lalg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [lalg_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input item
	input  logic [lalg_pkg::CH_W-1:0]          in_channel,
	input  logic [lalg_pkg::SAMPLE_W-1:0]      in_sample,
	input  logic [lalg_pkg::LEVEL_W-1:0]       in_peak,
	input  logic                               in_last,
	// result
	output logic [lalg_pkg::SAMPLE_W-1:0]      out_sample,
	output logic [lalg_pkg::CH_W-1:0]          out_channel,
	output logic [lalg_pkg::GAIN_W-1:0]        out_gain
);

	// configuration
	logic [lalg_pkg::LEVEL_W-1:0]  thr_q;
	logic [lalg_pkg::COEF_W-1:0]   att_q;
	logic [lalg_pkg::COEF_W-1:0]   rel_q;

	// per-channel gain state
	logic [lalg_pkg::GAIN_W-1:0]   gain_q [lalg_pkg::CHANNELS];

	// item registers
	logic [lalg_pkg::CH_W-1:0]     ch_q;
	logic [lalg_pkg::LEVEL_W-1:0]  mag_q;
	logic                          neg_q;
	logic [lalg_pkg::LEVEL_W-1:0]  peak_q;
	logic                          last_q;
	logic [lalg_pkg::GAIN_W-1:0]   gain_old_q;
	logic [lalg_pkg::GAIN_W-1:0]   target_q;
	logic [lalg_pkg::COEF_W-1:0]   w_q;
	logic [lalg_pkg::PROD_W-1:0]   acc_q;
	logic [lalg_pkg::GAIN_W-1:0]   gain_new_q;
	logic [lalg_pkg::GAIN_W-1:0]   applied_q;

	// output payload
	logic [lalg_pkg::SAMPLE_W-1:0] out_sample_q;
	logic [lalg_pkg::CH_W-1:0]     out_ch_q;
	logic [lalg_pkg::GAIN_W-1:0]   out_gain_q;

	logic [lalg_pkg::IDX_W-1:0]    idx;
	logic [lalg_pkg::LEVEL_W-1:0]  in_mag;
	logic [lalg_pkg::LEVEL_W-1:0]  mag1;
	logic [lalg_pkg::LEVEL_W-1:0]  div_den;
	logic                          div_busy;
	logic [lalg_pkg::QUO_W-1:0]    quo;
	logic [lalg_pkg::GAIN_W-1:0]   quo_g;
	logic [lalg_pkg::COEF_W-1:0]   att_sat;
	logic [lalg_pkg::COEF_W-1:0]   rel_sat;
	logic [lalg_pkg::GAIN_W-1:0]   mul_a;
	logic [lalg_pkg::LEVEL_W-1:0]  mul_b;
	logic [lalg_pkg::PROD_W-1:0]   prod;
	logic [lalg_pkg::GAIN_W-1:0]   smoothed;
	logic [lalg_pkg::SAMPLE_W-1:0] scaled_mag;

	assign idx     = ch_q[lalg_pkg::IDX_W-1:0];
	// two's complement magnitude; most negative sample gives 2^23, which fits
	assign in_mag  = in_sample[lalg_pkg::SAMPLE_W-1] ? (~in_sample + 1'b1) : in_sample;
	assign mag1    = (mag_q == '0) ? lalg_pkg::LEVEL_W'(1) : mag_q;
	assign div_den = cmd.div_sel ? mag1 : peak_q;
	assign quo_g   = {1'b0, quo};
	assign att_sat = (att_q > lalg_pkg::UNITY_GAIN) ? lalg_pkg::UNITY_GAIN : att_q;
	assign rel_sat = (rel_q > lalg_pkg::UNITY_GAIN) ? lalg_pkg::UNITY_GAIN : rel_q;
	assign smoothed   = acc_q[lalg_pkg::FRAC_W +: lalg_pkg::GAIN_W];
	assign scaled_mag = acc_q[lalg_pkg::FRAC_W +: lalg_pkg::SAMPLE_W];

	lalg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (thr_q),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (quo)
	);

	assign sts.div_busy = div_busy;

	// one shared multiplier
	always_comb begin
		if (cmd.scale) begin
			mul_a = applied_q;
			mul_b = mag_q;
		end else if (cmd.mul2) begin
			mul_a = lalg_pkg::UNITY_GAIN - w_q;
			mul_b = lalg_pkg::LEVEL_W'(target_q);
		end else begin
			mul_a = w_q;
			mul_b = lalg_pkg::LEVEL_W'(gain_old_q);
		end
		prod = lalg_pkg::PROD_W'(mul_a) * lalg_pkg::PROD_W'(mul_b);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= lalg_pkg::THRESHOLD_RST;
			att_q <= lalg_pkg::ATTACK_RST;
			rel_q <= lalg_pkg::RELEASE_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				lalg_pkg::REG_THRESHOLD: thr_q <= cfg_data;
				lalg_pkg::REG_ATTACK:    att_q <= cfg_data[lalg_pkg::COEF_W-1:0];
				lalg_pkg::REG_RELEASE:   rel_q <= cfg_data[lalg_pkg::COEF_W-1:0];
				default: ;
			endcase
		end
	end

	// gain state, unity after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lalg_pkg::CHANNELS; i++)
				gain_q[i] <= lalg_pkg::UNITY_GAIN;
		end else if (cmd.upd) begin
			gain_q[idx] <= last_q ? lalg_pkg::UNITY_GAIN : smoothed;
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q       <= in_channel;
			mag_q      <= in_mag;
			neg_q      <= in_sample[lalg_pkg::SAMPLE_W-1];
			peak_q     <= (in_peak == '0) ? lalg_pkg::LEVEL_W'(1) : in_peak;
			last_q     <= in_last;
			gain_old_q <= gain_q[in_channel[lalg_pkg::IDX_W-1:0]];
		end
		if (cmd.take_target)
			target_q <= (peak_q <= thr_q) ? lalg_pkg::UNITY_GAIN : quo_g;
		if (cmd.sel_weight)
			w_q <= (target_q < gain_old_q) ? att_sat : rel_sat;
		if (cmd.mul1 || cmd.scale)
			acc_q <= prod;
		else if (cmd.mul2)
			acc_q <= acc_q + prod;
		if (cmd.upd)
			gain_new_q <= smoothed;
		if (cmd.take_clamp) begin
			// |sample| <= threshold: clamp is at least unity, gain passes
			if (mag1 <= thr_q || gain_new_q < quo_g)
				applied_q <= gain_new_q;
			else
				applied_q <= quo_g;
		end
		if (cmd.out_load) begin
			out_sample_q <= neg_q ? (~scaled_mag + 1'b1) : scaled_mag;
			out_ch_q     <= ch_q;
			out_gain_q   <= applied_q;
		end
	end

	assign out_sample  = out_sample_q;
	assign out_channel = out_ch_q;
	assign out_gain    = out_gain_q;

endmodule

/* design/lalg_ctrl.sv */
// ----------------------------------------------------------------------------
// lalg_ctrl: sequencing state machine
// Steps one item through the datapath and owns the input ready and the
// output valid flag.
// ----------------------------------------------------------------------------
module lalg_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  lalg_pkg::lalg_sts_t  sts,
	output lalg_pkg::lalg_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DIVT  = 4'd1;
	localparam logic [3:0] S_WAITT = 4'd2;
	localparam logic [3:0] S_DIVC  = 4'd3;
	localparam logic [3:0] S_MUL1  = 4'd4;
	localparam logic [3:0] S_MUL2  = 4'd5;
	localparam logic [3:0] S_UPD   = 4'd6;
	localparam logic [3:0] S_WAITC = 4'd7;
	localparam logic [3:0] S_CLAMP = 4'd8;
	localparam logic [3:0] S_SCALE = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_DIVT;
				end
			end
			S_DIVT: begin
				cmd.div_start = 1'b1;
				state_d       = S_WAITT;
			end
			S_WAITT: begin
				if (!sts.div_busy) begin
					cmd.take_target = 1'b1;
					state_d         = S_DIVC;
				end
			end
			S_DIVC: begin
				// clamp division overlaps the smoothing steps
				cmd.div_start  = 1'b1;
				cmd.div_sel    = 1'b1;
				cmd.sel_weight = 1'b1;
				state_d        = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_d = S_WAITC;
			end
			S_WAITC: begin
				if (!sts.div_busy) begin
					cmd.div_sel    = 1'b1;
					cmd.take_clamp = 1'b1;
					state_d        = S_SCALE;
				end
			end
			S_CLAMP: begin
				state_d = S_SCALE;
			end
			S_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

/* design/lookahead_limiter_gain.sv */
// ----------------------------------------------------------------------------
// lookahead_limiter_gain: multichannel brick-wall limiter gain stage
// Smooths a per-channel gain toward threshold/peak, clamps it so the output
// magnitude stays at or below threshold, and scales the sample by it.
// ----------------------------------------------------------------------------
// One item enters on the slave stream, one result leaves on the master
// stream, in order. The result is loaded into the output register once the
// serial divider has run twice for the item, and the input is ready again in
// the next cycle; a new item is taken only when the last one is done. The
// divider produces one quotient bit a clock and runs twice per item
// (threshold/peak, then threshold/|sample|, the second overlapped with the
// gain smoothing multiplies); the other steps are sequencing around the two
// divisions. The result sits in an output register, so a stalled master
// only holds the block once a second result is done.
// Gains are Q1.16 (65536 is unity), samples and levels Q1.23; all results truncate
// toward zero, a zero peak or zero sample counts as one LSB, and a transaction
// with tlast set returns its channel's gain to unity after that sample is processed.
// The user must write configuration only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module lookahead_limiter_gain (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration: 0 threshold, 1 attack weight, 2 release weight
	input  logic                               cfg_we,
	input  logic [lalg_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [lalg_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [lalg_pkg::S_TDATA_W-1:0]     s_tdata,  // sample[23:0], peak_level[47:24]
	input  logic [lalg_pkg::CH_W-1:0]          s_tuser,  // channel[2:0]
	input  logic                               s_tlast,  // last_in_block
	// output stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [lalg_pkg::M_TDATA_W-1:0]     m_tdata,  // out_sample[23:0], applied_gain[40:24], zero[47:41]
	output logic [lalg_pkg::CH_W-1:0]          m_tuser   // out_channel[2:0]
);

	lalg_pkg::lalg_cmd_t            cmd;
	lalg_pkg::lalg_sts_t            sts;
	logic [lalg_pkg::SAMPLE_W-1:0]  out_sample;
	logic [lalg_pkg::GAIN_W-1:0]    out_gain;

	lalg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lalg_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_data    (cfg_data),
		.in_channel  (s_tuser),
		.in_sample   (s_tdata[lalg_pkg::SAMPLE_W-1:0]),
		.in_peak     (s_tdata[lalg_pkg::SAMPLE_W +: lalg_pkg::LEVEL_W]),
		.in_last     (s_tlast),
		.out_sample  (out_sample),
		.out_channel (m_tuser),
		.out_gain    (out_gain)
	);

	// pack result word, pad to whole bytes
	assign m_tdata = {{(lalg_pkg::M_TDATA_W - lalg_pkg::SAMPLE_W - lalg_pkg::GAIN_W){1'b0}},
		out_gain, out_sample};

endmodule

/* design/lalg_checker.sv */
// ----------------------------------------------------------------------------
// lalg_checker: port-level checks for lookahead_limiter_gain
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module lalg_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	input  logic                               s_tready,
	input  logic                               m_tvalid,
	input  logic                               m_tready,
	input  logic [lalg_pkg::M_TDATA_W-1:0]     m_tdata,
	input  logic [lalg_pkg::CH_W-1:0]          m_tuser
);

	// a stalled result stays valid
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a stalled result holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one item at a time: after a transaction the input is not ready at once
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after a transaction");

	// applied gain never exceeds unity, pad bits stay zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[40:24] <= lalg_pkg::UNITY_GAIN) && (m_tdata[47:41] == '0))
		else $error("applied gain above unity or pad bits set");

endmodule

bind lookahead_limiter_gain lalg_checker u_lalg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* tb/sv/limiter_gain_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// limiter_gain_checker: scoreboard for the look-ahead limiter gain stage
// Tracks register writes and per-channel gain state and computes the
// expected limited sample for each input transaction. Each output
// transaction is compared field by field against the oldest entry.
// ----------------------------------------------------------------------------
module limiter_gain_checker
	import lalg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,   // sample[23:0], peak_level[47:24]
	input  logic [CH_W-1:0]       s_tuser,   // channel[2:0]
	input  logic                  s_tlast,   // last_in_block
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [M_TDATA_W-1:0]  m_tdata,   // out_sample[23:0], applied_gain[40:24]
	input  logic [CH_W-1:0]       m_tuser,   // out_channel[2:0]
	output int                    errors,
	output int                    pending
);

	typedef struct packed {
		logic [SAMPLE_W-1:0] smp;
		logic [CH_W-1:0]     ch;
		logic [GAIN_W-1:0]   gain;
	} limited_t;

	logic [LEVEL_W-1:0] thr;
	logic [COEF_W-1:0]  att;
	logic [COEF_W-1:0]  rel;
	logic [GAIN_W-1:0]  gain_mem [CHANNELS];
	limited_t           limited_q [$];

	// weights above 1.0 saturate: gain holds
	function automatic logic [63:0] weight_sat(input logic [COEF_W-1:0] w);
		return (w > UNITY_GAIN) ? 64'(UNITY_GAIN) : 64'(w);
	endfunction

	// one sample through the gain stage; updates the channel's gain
	function automatic limited_t limit_item(input logic [CH_W-1:0] ch,
			input logic [SAMPLE_W-1:0] raw, input logic [LEVEL_W-1:0] pk,
			input logic last);
		logic        neg;
		logic [63:0] mag, pkv, target, clamp, applied, g, w, prod;
		int          idx;
		limited_t    r;
		neg = raw[SAMPLE_W-1];
		mag = neg ? (64'd1 << SAMPLE_W) - 64'(raw) : 64'(raw);
		pkv = (pk == 0) ? 64'd1 : 64'(pk);     // zero peak stands in as one LSB
		target = (pkv <= 64'(thr)) ? 64'(UNITY_GAIN) : (64'(thr) << FRAC_W) / pkv;
		idx = ch % CHANNELS;
		g = 64'(gain_mem[idx]);
		w = (target < g) ? weight_sat(att) : weight_sat(rel);
		g = (w * g + (64'(UNITY_GAIN) - w) * target) >> FRAC_W;
		clamp = (64'(thr) << FRAC_W) / ((mag == 0) ? 64'd1 : mag);
		applied = (g < clamp) ? g : clamp;
		prod = (applied * mag) >> FRAC_W;
		r.smp = neg ? SAMPLE_W'(64'd0 - prod) : SAMPLE_W'(prod);
		r.ch = ch;
		r.gain = GAIN_W'(applied);
		gain_mem[idx] = last ? UNITY_GAIN : GAIN_W'(g);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		limited_t due, got;
		if (!arst_n) begin
			thr = THRESHOLD_RST;
			att = ATTACK_RST;
			rel = RELEASE_RST;
			for (int i = 0; i < CHANNELS; i++)
				gain_mem[i] = UNITY_GAIN;
			limited_q.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_THRESHOLD: thr = cfg_data[LEVEL_W-1:0];
					REG_ATTACK:    att = cfg_data[COEF_W-1:0];
					REG_RELEASE:   rel = cfg_data[COEF_W-1:0];
					default: ;
				endcase
			end
			// output side first: a result never leaves in its own input cycle
			if (m_tvalid && m_tready) begin
				got.smp  = m_tdata[SAMPLE_W-1:0];
				got.gain = m_tdata[SAMPLE_W +: GAIN_W];
				got.ch   = m_tuser;
				if (limited_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: expected none, actual sample %0d gain %0d ch %0d",
						$time, $signed(got.smp), got.gain, got.ch);
				end else begin
					due = limited_q.pop_front();
					if (got.smp !== due.smp) begin
						errors++;
						$display("%0t: out_sample mismatch: expected %0d actual %0d",
							$time, $signed(due.smp), $signed(got.smp));
					end
					if (got.gain !== due.gain) begin
						errors++;
						$display("%0t: applied_gain mismatch: expected %0d actual %0d",
							$time, due.gain, got.gain);
					end
					if (got.ch !== due.ch) begin
						errors++;
						$display("%0t: out_channel mismatch: expected %0d actual %0d",
							$time, due.ch, got.ch);
					end
				end
			end
			if (s_tvalid && s_tready)
				limited_q.push_back(limit_item(s_tuser, s_tdata[SAMPLE_W-1:0],
					s_tdata[SAMPLE_W +: LEVEL_W], s_tlast));
			pending <= limited_q.size();
		end
	end

endmodule

/* tb/sv/tb_lookahead_limiter_gain.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lookahead_limiter_gain: stimulus and verdict for the limiter gain stage
// A directed pass over field extremes and register corner settings, then
// random sample/peak streams under changing thresholds and weights, with
// random stalls on both streams. Checking lives in limiter_gain_checker.
// ----------------------------------------------------------------------------
module tb_lookahead_limiter_gain;
	import lalg_pkg::*;

	localparam int unsigned FULL_SCALE  = 8388608;  // 1.0 in Q1.23
	localparam int          HOLD_CYCLES = 400;      // long output back-pressure
	localparam int          QUIET_LIMIT = 5000;     // cycles with no transaction
	localparam int          ITEMS_PER_SETTING = 130;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  cfg_we   = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata  = '0;  // sample[23:0], peak_level[47:24]
	logic [CH_W-1:0]       s_tuser  = '0;  // channel[2:0]
	logic                  s_tlast  = 1'b0;  // last_in_block
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;  // out_sample[23:0], applied_gain[40:24], zero[47:41]
	logic [CH_W-1:0]       m_tuser;  // out_channel[2:0]

	int          errors;
	int          pending;
	int          send_idle = 0;  // percent of cycles the sender holds back
	int          recv_idle = 0;  // percent of cycles the receiver stalls
	int unsigned cur_thr   = FULL_SCALE;
	logic        hold_tog  = 1'b0;  // toggled to request a long receiver hold-off
	logic        hold_seen = 1'b0;
	int          hold_cnt  = 0;
	int          quiet     = 0;

	lookahead_limiter_gain dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	limiter_gain_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver: random stalls, plus a counted hold-off on request. During the
	// hold-off the sender keeps offering, so the output register and the
	// in-flight item fill up and s_tready drops.
	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			m_tready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else if (hold_tog != hold_seen) begin
			hold_seen <= hold_tog;
			hold_cnt <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else
			m_tready <= ($urandom_range(99) >= recv_idle);
	end

	// Watchdog: ends the run if nothing moves on either stream for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet <= 0;
		else if (quiet >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	// One input transaction; valid stays high afterwards unless the next call
	// opens a gap, so back-to-back items never lower and raise it in one step.
	task automatic send_item(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] smp,
			input logic [LEVEL_W-1:0] pk, input logic last);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {pk, smp};
		s_tuser <= ch;
		s_tlast <= last;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Sender pauses until every result is back, then all three registers
	// are written on consecutive cycles while the block is idle.
	task automatic program_limiter(input logic [LEVEL_W-1:0] thr,
			input logic [COEF_W-1:0] att, input logic [COEF_W-1:0] rel);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= REG_THRESHOLD;
		cfg_data <= CFG_DATA_W'(thr);
		@(posedge clk);
		cfg_addr <= REG_ATTACK;
		cfg_data <= CFG_DATA_W'(att);
		@(posedge clk);
		cfg_addr <= REG_RELEASE;
		cfg_data <= CFG_DATA_W'(rel);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_thr = thr;
	endtask

	// smoothing weights: off, exactly 1.0, slow, anywhere up to 1.0, or any 17-bit value, often above 1.0
	function automatic logic [COEF_W-1:0] pick_weight();
		case ($urandom_range(4))
			0: return '0;
			1: return UNITY_GAIN;
			2: return COEF_W'($urandom_range(65535, 60000));
			3: return COEF_W'($urandom_range(65536));
			default: return COEF_W'($urandom);
		endcase
	endfunction

	initial begin
		int unsigned pk, mag;
		logic [SAMPLE_W-1:0] smp;
		logic [LEVEL_W-1:0] thr;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		send_idle = 13;
		recv_idle = 81;
		@(posedge clk);

		// --- directed: reset settings (threshold 1.0, instant attack) ---
		send_item(3'd0, 24'h7FFFFF, 24'h800000, 1'b0);  // peak equal to threshold
		send_item(3'd1, 24'h800000, 24'h000000, 1'b0);  // most negative, zero peak
		send_item(3'd2, 24'h000000, 24'h000000, 1'b0);  // zero sample and peak
		send_item(3'd7, 24'hFFFFFF, 24'h800000, 1'b1);  // -1 LSB, block end
		send_item(3'd3, 24'h000001, 24'h000001, 1'b0);

		// threshold 0.25: hard attack, then release back toward unity
		program_limiter(24'h200000, 17'd0, 17'd65000);
		send_item(3'd0, 24'h7FFFFF, 24'h800000, 1'b0);
		send_item(3'd0, 24'hC00000, 24'h400000, 1'b0);
		send_item(3'd0, 24'h100000, 24'h100000, 1'b0);
		send_item(3'd0, 24'h000000, 24'h100000, 1'b1);  // zero sample at block end
		send_item(3'd0, 24'h000064, 24'h300000, 1'b0);

		// smallest threshold, both weights above 1.0: gain frozen, clamp rules
		program_limiter(24'h000001, 17'h1FFFF, 17'h1FFFF);
		send_item(3'd5, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
		send_item(3'd5, 24'h000001, 24'h000000, 1'b0);
		send_item(3'd6, 24'hFFFFFE, 24'h000002, 1'b1);

		// zero threshold: target and clamp both zero
		program_limiter(24'h000000, UNITY_GAIN, 17'd0);
		send_item(3'd4, 24'h555555, 24'h2AAAAA, 1'b0);
		send_item(3'd4, 24'hD55556, 24'h000000, 1'b1);

		// threshold above 1.0: clamp exceeds unity
		program_limiter(24'hFFFFFF, 17'h08000, UNITY_GAIN);
		send_item(3'd3, 24'h800000, 24'h800000, 1'b0);
		send_item(3'd3, 24'h7FFFFF, 24'h000000, 1'b0);

		// partial weights: gradual attack and release on one channel
		program_limiter(24'h600000, 17'h08000, 17'h04000);
		send_item(3'd1, 24'h7FFFFF, 24'h800000, 1'b0);
		send_item(3'd1, 24'h800001, 24'h800000, 1'b0);
		send_item(3'd1, 24'h123456, 24'h123456, 1'b0);
		send_item(3'd1, 24'h9ABCDF, 24'h654321, 1'b1);
		send_item(3'd2, 24'h0ABCDE, 24'h7FFFFF, 1'b0);

		// --- random: three idling patterns, four register settings each ---
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle = 13;
					recv_idle = 81;
				end
				1: begin
					send_idle = 81;
					recv_idle = 13;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			for (int seg = 0; seg < 4; seg++) begin
				case ($urandom_range(4))
					0: thr = LEVEL_W'(FULL_SCALE);
					1: thr = LEVEL_W'($urandom_range(FULL_SCALE, 1));
					2: thr = LEVEL_W'($urandom_range(24'h100000, 1));
					3: thr = LEVEL_W'($urandom_range(24'h7FFFFF, 24'h400000));
					default: thr = LEVEL_W'($urandom);
				endcase
				program_limiter(thr, pick_weight(), pick_weight());
				for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
					if (phase == 2 && seg == 1 && n == 20)
						hold_tog <= ~hold_tog;
					// peaks cluster around the threshold so gains keep moving
					case ($urandom_range(9))
						0: pk = 0;
						1: pk = FULL_SCALE;
						2, 3, 4, 5: pk = (cur_thr < FULL_SCALE) ?
							$urandom_range(FULL_SCALE, cur_thr + 1) : $urandom_range(FULL_SCALE);
						6, 7, 8: pk = $urandom_range((cur_thr < FULL_SCALE) ? cur_thr : FULL_SCALE);
						default: pk = $urandom_range(FULL_SCALE);
					endcase
					// mostly samples no louder than their peak; some raw noise
					if ($urandom_range(4) == 0)
						smp = SAMPLE_W'($urandom);
					else begin
						mag = $urandom_range(pk);
						if ($urandom_range(1) == 1)
							smp = SAMPLE_W'(-int'(mag));
						else
							smp = SAMPLE_W'((mag > FULL_SCALE - 1) ? FULL_SCALE - 1 : mag);
					end
					send_item(CH_W'($urandom_range(CHANNELS - 1)), smp, LEVEL_W'(pk),
						($urandom_range(31) == 0));
				end
			end
		end

		// drain, then give the block room to emit anything stray
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* filelist.f */
design/lalg_pkg.sv
design/lalg_div.sv
design/lalg_datapath.sv
design/lalg_ctrl.sv
design/lookahead_limiter_gain.sv
design/lalg_checker.sv
tb/sv/limiter_gain_checker.sv
tb/sv/tb_lookahead_limiter_gain.sv
